/* rtl/core/dhc_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helper functions of the disparity colorizer
package dhc_pkg;

    // pixel and register geometry
    localparam int PIXEL_BITS = 8;
    localparam int Q_W        = 9;
    localparam int NUM_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    // hue span of the colormap in degrees
    localparam int HUE_SPAN = 240;

    // request kinds
    localparam logic REQ_MEASURE  = 1'b0;
    localparam logic REQ_COLORIZE = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIXED_MAX  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SATURATION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd2;

    // input word
    typedef struct packed {
        logic                  req_type;
        logic                  frame_start;
        logic [PIXEL_BITS-1:0] disparity;
    } dhc_in_t;

    // output word
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } dhc_out_t;

    // configuration registers
    typedef struct packed {
        logic [PIXEL_BITS-1:0] fixed_max;
        logic [Q_W-1:0]        saturation;
        logic [Q_W-1:0]        brightness;
    } dhc_cfg_t;

    // job handed from the front to the back: black flag, maximum, hue numerator
    typedef struct packed {
        logic                  black;
        logic [PIXEL_BITS-1:0] maxv;
        logic [NUM_W-1:0]      num;
    } dhc_job_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } dhc_fifo_stat_t;

    // back end status
    typedef struct packed {
        logic busy;
    } dhc_back_stat_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [PIXEL_BITS:0] div_step(
        input logic [PIXEL_BITS-1:0] rem,
        input logic                  din,
        input logic [PIXEL_BITS-1:0] dv
    );
        logic [PIXEL_BITS:0] trial;
        logic [PIXEL_BITS:0] diff;
        trial = {rem, din};
        diff  = trial - {1'b0, dv};
        if (trial >= {1'b0, dv}) begin
            return {1'b1, diff[PIXEL_BITS-1:0]};
        end else begin
            return {1'b0, trial[PIXEL_BITS-1:0]};
        end
    endfunction

endpackage

/* rtl/core/dhc_front.sv */
`timescale 1ns / 1ps
// front end: takes pixels, tracks the frame maximum, queues colorize jobs
module dhc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dhc_pkg::dhc_in_t  s_data,
    input  dhc_pkg::dhc_cfg_t cfg,
    input  dhc_pkg::dhc_fifo_stat_t fifo_stat,
    output logic              push,
    output dhc_pkg::dhc_job_t job
);
    import dhc_pkg::*;

    logic [PIXEL_BITS-1:0] frame_max_reg;
    logic [PIXEL_BITS-1:0] frame_max_next;
    logic [PIXEL_BITS-1:0] max_sel;
    logic [PIXEL_BITS-1:0] disp_clamp;
    logic [PIXEL_BITS-1:0] span;
    logic                  accept;

    // a word is taken whenever the queue has room
    assign s_ready = !fifo_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_data.req_type == REQ_COLORIZE);

    // maximum in use, clamped pixel and hue numerator
    always_comb begin
        max_sel    = (cfg.fixed_max != '0) ? cfg.fixed_max : frame_max_reg;
        disp_clamp = (s_data.disparity > max_sel) ? max_sel : s_data.disparity;
        span       = max_sel - disp_clamp;
        job.black  = (max_sel == '0);
        job.maxv   = max_sel;
        job.num    = NUM_W'(span) * NUM_W'(HUE_SPAN);
    end

    // running maximum of the measure pass
    always_comb begin
        frame_max_next = frame_max_reg;
        if (accept && (s_data.req_type == REQ_MEASURE)) begin
            if (s_data.frame_start || (s_data.disparity > frame_max_reg)) begin
                frame_max_next = s_data.disparity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_max_reg <= '0;
        end else begin
            frame_max_reg <= frame_max_next;
        end
    end

endmodule

/* rtl/core/dhc_fifo.sv */
`timescale 1ns / 1ps
// two-entry job queue between the front and the back
module dhc_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  dhc_pkg::dhc_job_t       wr_data,
    input  logic                    pop,
    output dhc_pkg::dhc_job_t       rd_data,
    output dhc_pkg::dhc_fifo_stat_t stat
);
    import dhc_pkg::*;

    dhc_job_t    mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/dhc_back.sv */
`timescale 1ns / 1ps
// back end: hue division, hsv to rgb conversion, scaling and output register
module dhc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dhc_pkg::dhc_cfg_t       cfg,
    input  dhc_pkg::dhc_job_t       job,
    input  dhc_pkg::dhc_fifo_stat_t fifo_stat,
    output logic                    pop,
    output dhc_pkg::dhc_back_stat_t stat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output dhc_pkg::dhc_out_t       m_data
);
    import dhc_pkg::*;

    localparam int TERM_W  = 17;
    localparam int PROD_W  = 27;
    localparam int CLAMP_W = 22;
    localparam int Z_W     = 12;
    localparam int QP_W    = 25;
    localparam int LANES   = 3;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_TERM = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_REC  = 3'd5;

    // hue sectors
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    // lane order
    localparam int LANE_B = 0;
    localparam int LANE_G = 1;
    localparam int LANE_R = 2;

    localparam logic signed [TERM_W-1:0] TERM_ONE  = 17'sd15360;
    localparam logic signed [PROD_W-1:0] DENOM_S   = 27'sd3932160;
    localparam logic [CLAMP_W-1:0]       DENOM     = 22'd3932160;
    localparam logic [QP_W-1:0]          RECIP_15  = 25'd4370;

    logic [2:0]            state_reg,  state_next;
    logic [1:0]            cnt_reg,    cnt_next;
    logic [PIXEL_BITS-1:0] maxv_reg,   maxv_next;
    logic [PIXEL_BITS-1:0] rem_reg,    rem_next;
    logic [PIXEL_BITS-1:0] low_reg,    low_next;
    logic [PIXEL_BITS-1:0] quo_reg,    quo_next;
    logic signed [TERM_W-1:0] term_reg [LANES];
    logic signed [TERM_W-1:0] term_next [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic [Z_W-1:0]        z_reg [LANES];
    logic [Z_W-1:0]        z_next [LANES];
    logic                  out_valid_reg, out_valid_next;
    dhc_out_t              out_reg,       out_next;

    logic                  out_free;
    logic [PIXEL_BITS:0]   step_a;
    logic [PIXEL_BITS:0]   step_b;
    logic [2:0]            sec;
    logic [PIXEL_BITS-1:0] frac8;
    logic [5:0]            frac;
    logic [5:0]            frac_inv;
    logic [14:0]           rs;
    logic [14:0]           rts;
    logic signed [9:0]     pdiff;
    logic signed [TERM_W-1:0] term_v, term_p, term_q, term_t;
    logic [CLAMP_W-1:0]    clamp_val [LANES];
    logic [29:0]           scaled [LANES];
    logic [QP_W-1:0]       qp [LANES];

    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign pop       = !fifo_stat.empty
                       && ((state_reg == ST_IDLE) || ((state_reg == ST_REC) && out_free));
    assign stat.busy = (state_reg != ST_IDLE);

    // two restoring division steps a cycle
    always_comb begin
        step_a = div_step(rem_reg, low_reg[PIXEL_BITS-1], maxv_reg);
        step_b = div_step(step_a[PIXEL_BITS-1:0], low_reg[PIXEL_BITS-2], maxv_reg);
    end

    // sector and fraction of the hue
    always_comb begin
        if (quo_reg >= 8'd240) begin
            sec = SEC_4; frac8 = quo_reg - 8'd240;
        end else if (quo_reg >= 8'd180) begin
            sec = SEC_3; frac8 = quo_reg - 8'd180;
        end else if (quo_reg >= 8'd120) begin
            sec = SEC_2; frac8 = quo_reg - 8'd120;
        end else if (quo_reg >= 8'd60) begin
            sec = SEC_1; frac8 = quo_reg - 8'd60;
        end else begin
            sec = SEC_0; frac8 = quo_reg;
        end
        frac     = frac8[5:0];
        frac_inv = 6'd60 - frac;
    end

    // v, p, q and t numerators before the brightness factor
    always_comb begin
        rs     = {9'b0, frac} * {6'b0, cfg.saturation};
        rts    = {9'b0, frac_inv} * {6'b0, cfg.saturation};
        pdiff  = $signed(10'd256) - $signed({1'b0, cfg.saturation});
        term_v = TERM_ONE;
        term_p = $signed({{7{pdiff[9]}}, pdiff}) * 17'sd60;
        term_q = TERM_ONE - $signed({2'b00, rs});
        term_t = TERM_ONE - $signed({2'b00, rts});
    end

    // clamp to 0..1, times 255, and the reciprocal multiply by 1/15 of the final divide
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (prod_reg[i][PROD_W-1]) begin
                clamp_val[i] = '0;
            end else if (prod_reg[i] > DENOM_S) begin
                clamp_val[i] = DENOM;
            end else begin
                clamp_val[i] = prod_reg[i][CLAMP_W-1:0];
            end
            scaled[i] = {clamp_val[i], 8'b0} - {8'b0, clamp_val[i]};
            qp[i]     = QP_W'(z_reg[i]) * RECIP_15;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        maxv_next      = maxv_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        term_next      = term_reg;
        prod_next      = prod_reg;
        z_next         = z_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_DIV: begin
                rem_next = step_b[PIXEL_BITS-1:0];
                low_next = {low_reg[PIXEL_BITS-3:0], 2'b00};
                quo_next = {quo_reg[PIXEL_BITS-3:0], step_a[PIXEL_BITS], step_b[PIXEL_BITS]};
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                case (sec)
                    SEC_0: begin
                        term_next[LANE_B] = term_p;
                        term_next[LANE_G] = term_t;
                        term_next[LANE_R] = term_v;
                    end
                    SEC_1: begin
                        term_next[LANE_B] = term_p;
                        term_next[LANE_G] = term_v;
                        term_next[LANE_R] = term_q;
                    end
                    SEC_2: begin
                        term_next[LANE_B] = term_t;
                        term_next[LANE_G] = term_v;
                        term_next[LANE_R] = term_p;
                    end
                    SEC_3: begin
                        term_next[LANE_B] = term_v;
                        term_next[LANE_G] = term_q;
                        term_next[LANE_R] = term_p;
                    end
                    SEC_4: begin
                        term_next[LANE_B] = term_v;
                        term_next[LANE_G] = term_p;
                        term_next[LANE_R] = term_t;
                    end
                    default: begin
                        term_next[LANE_B] = term_q;
                        term_next[LANE_G] = term_p;
                        term_next[LANE_R] = term_v;
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                for (int i = 0; i < LANES; i++) begin
                    prod_next[i] = $signed({1'b0, cfg.brightness}) * term_reg[i];
                end
                state_next = ST_SCL;
            end
            ST_SCL: begin
                for (int i = 0; i < LANES; i++) begin
                    z_next[i] = scaled[i][29:18];
                end
                state_next = ST_REC;
            end
            ST_REC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.blue  = qp[LANE_B][23:16];
                    out_next.green = qp[LANE_G][23:16];
                    out_next.red   = qp[LANE_R][23:16];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // next job from the queue
        if (pop) begin
            maxv_next = job.maxv;
            rem_next  = job.num[NUM_W-1:PIXEL_BITS];
            low_next  = job.num[PIXEL_BITS-1:0];
            quo_next  = '0;
            cnt_next  = '0;
            if (job.black) begin
                for (int i = 0; i < LANES; i++) begin
                    z_next[i] = '0;
                end
                state_next = ST_REC;
            end else begin
                state_next = ST_DIV;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        maxv_reg  <= maxv_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quo_reg   <= quo_next;
        term_reg  <= term_next;
        prod_reg  <= prod_next;
        z_reg     <= z_next;
        out_reg   <= out_next;
    end

endmodule

/* rtl/core/disparity_hsv_colorizer.sv */
`timescale 1ns / 1ps
// top level of the disparity hsv colorizer
//
//  channel   dir   handshake                  word
//  s_        in    s_valid / s_ready          req_type, frame_start, disparity
//  m_        out   m_valid / m_ready          blue, green, red
//  cfg_      in    cfg_wr_en                  cfg_addr, cfg_wr_data
//
// measure words only update the frame maximum; a colorize word keeps the back end busy
// through the divide steps at two quotient bits each, then term, multiply, scale and
// reciprocal steps, the next job loading in the reciprocal state; black pixels go straight to the reciprocal step.
// synchronous active-low reset clears control state; the frame maximum resets to 0.
// a stalled m_ holds its word; s_ready drops once the two-entry queue is full.
module disparity_hsv_colorizer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dhc_pkg::dhc_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dhc_pkg::dhc_out_t                    m_data,
    input  logic                                 cfg_wr_en,
    input  logic [dhc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [dhc_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import dhc_pkg::*;

    dhc_cfg_t       cfg_reg;
    dhc_cfg_t       cfg_next;
    dhc_job_t       push_job;
    dhc_job_t       pop_job;
    dhc_fifo_stat_t fifo_stat;
    dhc_back_stat_t back_stat;
    logic           push;
    logic           pop;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FIXED_MAX:  cfg_next.fixed_max  = cfg_wr_data[PIXEL_BITS-1:0];
                REG_SATURATION: cfg_next.saturation = cfg_wr_data[Q_W-1:0];
                REG_BRIGHTNESS: cfg_next.brightness = cfg_wr_data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fixed_max  <= '0;
            cfg_reg.saturation <= 9'd256;
            cfg_reg.brightness <= 9'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    dhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .job       (push_job)
    );

    // job queue
    dhc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (push_job),
        .pop     (pop),
        .rd_data (pop_job),
        .stat    (fifo_stat)
    );

    // back end
    dhc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job       (pop_job),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .stat      (back_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // measure words never enter the queue
    a_measure_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.req_type == REQ_MEASURE)) |-> !push)
        else $error("measure word pushed into the job queue");

    // an accepted colorize word is waiting in the queue on the next cycle
    a_colorize_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.req_type == REQ_COLORIZE)) |=> !fifo_stat.empty)
        else $error("colorize word lost on the way into the queue");

    // a new result only comes out of a busy back end
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_stat.busy))
        else $error("result word appeared without back end work");

endmodule

/* sim/tb_disparity_hsv_colorizer.sv */
`timescale 1ns / 1ps
// self-checking testbench of the disparity hsv colorizer with a built-in hsv colormap predictor
module tb_disparity_hsv_colorizer;
    import dhc_pkg::*;

    localparam longint HSV_DENOM  = 64'd3932160;   // 256 * 256 * 60
    localparam int     QUIET_LIMIT = 4000;
    localparam int     LONG_HOLD   = 300;
    localparam int     NUM_PHASES  = 8;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // block ports
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    dhc_in_t               s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    dhc_out_t              m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // predictor copy of the registers and the running frame maximum
    logic [PIXEL_BITS-1:0] cfg_fixed_max  = '0;
    logic [Q_W-1:0]        cfg_saturation = 9'd256;
    logic [Q_W-1:0]        cfg_brightness = 9'd256;
    logic [PIXEL_BITS-1:0] frame_peak     = '0;

    // pixel words waiting to be sent and colours waiting to come back
    dhc_in_t  pixel_q[$];
    dhc_out_t colour_q[$];

    // idling control
    int send_idle_pct = 13;
    int recv_idle_pct = 50;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    // run statistics
    int mismatch_count = 0;
    int result_count   = 0;
    int measure_count  = 0;
    int quiet_cycles   = 0;

    disparity_hsv_colorizer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // clamp a channel numerator to 0..1 and scale to 0..255
    function automatic logic [7:0] channel_level(longint num);
        longint c;
        c = num;
        if (c < 0) c = 0;
        if (c > HSV_DENOM) c = HSV_DENOM;
        return 8'((c * 255) / HSV_DENOM);
    endfunction

    // expected colour of one pixel under the current registers and frame maximum
    function automatic dhc_out_t colour_of(logic [PIXEL_BITS-1:0] pix);
        int       top_i;
        int       d_i;
        int       hue;
        int       sector;
        int       frac;
        longint   s;
        longint   v;
        longint   vn;
        longint   pn;
        longint   qn;
        longint   tn;
        dhc_out_t c;
        c     = '0;
        top_i = (cfg_fixed_max != 0) ? int'(cfg_fixed_max) : int'(frame_peak);
        if (top_i == 0) return c;
        d_i = (int'(pix) > top_i) ? top_i : int'(pix);
        hue    = (top_i - d_i) * HUE_SPAN / top_i;
        sector = hue / 60;
        frac   = hue % 60;
        s  = longint'(cfg_saturation);
        v  = longint'(cfg_brightness);
        vn = v * 256 * 60;
        pn = v * (256 - s) * 60;
        qn = v * (15360 - frac * s);
        tn = v * (15360 - (60 - frac) * s);
        case (sector)
            0: begin
                c.blue = channel_level(pn); c.green = channel_level(tn); c.red = channel_level(vn);
            end
            1: begin
                c.blue = channel_level(pn); c.green = channel_level(vn); c.red = channel_level(qn);
            end
            2: begin
                c.blue = channel_level(tn); c.green = channel_level(vn); c.red = channel_level(pn);
            end
            3: begin
                c.blue = channel_level(vn); c.green = channel_level(qn); c.red = channel_level(pn);
            end
            4: begin
                c.blue = channel_level(vn); c.green = channel_level(pn); c.red = channel_level(tn);
            end
            default: begin
                c.blue = channel_level(qn); c.green = channel_level(pn); c.red = channel_level(vn);
            end
        endcase
        return c;
    endfunction

    // driver: offer the next pending word, holding it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pixel_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: check returned colours, then predict for the accepted pixel word
    always @(posedge aclk) begin
        dhc_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count++;
                if (colour_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected colour word b=%0d g=%0d r=%0d", $realtime,
                             m_data.blue, m_data.green, m_data.red);
                end else begin
                    want = colour_q.pop_front();
                    if (m_data.blue !== want.blue) begin
                        mismatch_count++;
                        $display("%0t: blue expected %0d actual %0d", $realtime,
                                 want.blue, m_data.blue);
                    end
                    if (m_data.green !== want.green) begin
                        mismatch_count++;
                        $display("%0t: green expected %0d actual %0d", $realtime,
                                 want.green, m_data.green);
                    end
                    if (m_data.red !== want.red) begin
                        mismatch_count++;
                        $display("%0t: red expected %0d actual %0d", $realtime,
                                 want.red, m_data.red);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_MEASURE) begin
                    measure_count++;
                    if (s_data.frame_start || s_data.disparity > frame_peak)
                        frame_peak = s_data.disparity;
                end else begin
                    colour_q.push_back(colour_of(s_data.disparity));
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
                $display("tb_disparity_hsv_colorizer: errors");
                $finish;
            end
        end
    end

    // register write, only used while the block is idle
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_FIXED_MAX:  cfg_fixed_max  = data[PIXEL_BITS-1:0];
            REG_SATURATION: cfg_saturation = data[Q_W-1:0];
            REG_BRIGHTNESS: cfg_brightness = data[Q_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every word is sent and every colour has come back
    // checked on the falling edge so the driver and monitor updates have settled
    task automatic wait_drained();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || colour_q.size() != 0);
    endtask

    task automatic push_word(logic kind, logic fs, logic [PIXEL_BITS-1:0] pix);
        dhc_in_t w;
        w.req_type    = kind;
        w.frame_start = fs;
        w.disparity   = pix;
        pixel_q.push_back(w);
    endtask

    // disparity biased toward the ends of the range
    function automatic logic [PIXEL_BITS-1:0] pick_disparity();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 15));
            3:       return 8'($urandom_range(240, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame: measure pass then colorize pass over the same pixels
    task automatic queue_frame(int n);
        logic [PIXEL_BITS-1:0] pix[$];
        pix = {};
        for (int i = 0; i < n; i++) begin
            pix.push_back(pick_disparity());
            push_word(REQ_MEASURE, i == 0, pix[i]);
        end
        for (int i = 0; i < n; i++)
            push_word(REQ_COLORIZE, 1'($urandom_range(0, 1)), pix[i]);
    endtask

    // stimulus and end of run
    initial begin
        int fm_tab[NUM_PHASES]  = '{0, 255, 1, 0, 100, 0, -1, 0};
        int sat_tab[NUM_PHASES] = '{256, 0, 511, 511, 128, 300, -1, 256};
        int bri_tab[NUM_PHASES] = '{256, 511, 0, 511, 200, 256, -1, 256};
        int added;
        int n;
        bit paused;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero maximum, every sector, clamping, frame restarts
        push_word(REQ_COLORIZE, 1'b0, 8'd0);
        push_word(REQ_COLORIZE, 1'b1, 8'd255);
        push_word(REQ_MEASURE,  1'b1, 8'd0);
        push_word(REQ_COLORIZE, 1'b0, 8'd0);
        push_word(REQ_MEASURE,  1'b1, 8'd240);
        push_word(REQ_MEASURE,  1'b0, 8'd10);
        push_word(REQ_COLORIZE, 1'b0, 8'd240);
        push_word(REQ_COLORIZE, 1'b0, 8'd180);
        push_word(REQ_COLORIZE, 1'b0, 8'd120);
        push_word(REQ_COLORIZE, 1'b0, 8'd60);
        push_word(REQ_COLORIZE, 1'b0, 8'd0);
        push_word(REQ_COLORIZE, 1'b0, 8'd200);
        push_word(REQ_COLORIZE, 1'b1, 8'd250);
        push_word(REQ_MEASURE,  1'b1, 8'd255);
        push_word(REQ_MEASURE,  1'b1, 8'd7);
        push_word(REQ_COLORIZE, 1'b0, 8'd7);
        push_word(REQ_COLORIZE, 1'b0, 8'd0);
        push_word(REQ_COLORIZE, 1'b0, 8'd3);
        push_word(REQ_MEASURE,  1'b0, 8'd255);
        push_word(REQ_COLORIZE, 1'b0, 8'd255);
        push_word(REQ_COLORIZE, 1'b0, 8'd128);
        push_word(REQ_COLORIZE, 1'b0, 8'd1);

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            repeat (20) @(posedge aclk);
            write_reg(REG_FIXED_MAX,
                      (fm_tab[ph] < 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                       : CFG_DATA_W'(fm_tab[ph]));
            write_reg(REG_SATURATION,
                      (sat_tab[ph] < 0) ? CFG_DATA_W'($urandom_range(0, 511))
                                        : CFG_DATA_W'(sat_tab[ph]));
            write_reg(REG_BRIGHTNESS,
                      (bri_tab[ph] < 0) ? CFG_DATA_W'($urandom_range(0, 511))
                                        : CFG_DATA_W'(bri_tab[ph]));

            if (ph < 3) begin
                send_idle_pct = 13; recv_idle_pct = 50;
            end else if (ph < 6) begin
                send_idle_pct = 50; recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;  recv_idle_pct = 0;
            end

            // long receiver hold-off while words keep coming
            if (ph == 1 || ph == 5)
                hold_token++;

            added  = 0;
            paused = 1'b0;
            while (added < 250) begin
                if ($urandom_range(0, 99) < 80) begin
                    n = $urandom_range(2, 24);
                    queue_frame(n);
                    added += 2 * n;
                end else begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)));
                    added += n;
                end
                // sender pause until all colours are back
                if (!paused && added >= 125) begin
                    paused = 1'b1;
                    wait_drained();
                end
                while (pixel_q.size() > 64) @(posedge aclk);
            end
        end

        wait_drained();
        repeat (30) @(posedge aclk);

        $display("ran %0d register settings: %0d measure words, %0d colour words checked",
                 NUM_PHASES + 1, measure_count, result_count);
        if (mismatch_count == 0) begin
            $display("tb_disparity_hsv_colorizer: clean");
        end else begin
            $display("tb_disparity_hsv_colorizer: errors");
        end
        $finish;
    end

endmodule
